@@ src/pat_pkg.sv @@
// ----------------------------------------------------------------------------
// Paged address translation package
// Shared widths, table size, status codes and register indexes.
// ----------------------------------------------------------------------------
package pat_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);

	localparam int ADDR_W   = 32;
	localparam int FRAME_W  = 16;
	localparam int ENTRY_W  = 6;
	localparam int STATUS_W = 2;
	localparam int PSIZE_W  = 17;
	localparam int PAGES_W  = 7;
	localparam int CFG_W    = 17;
	localparam int CFG_IDX_W = 1;

	localparam int DIV_STEPS = ADDR_W;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);

	localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST = PSIZE_W'(4096);
	localparam logic [PAGES_W-1:0] PAGES_RST     = PAGES_W'(64);

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] ST_WRITTEN = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAGES_IN_USE = 1'd1;

	localparam logic MODE_WRITE     = 1'b0;
	localparam logic MODE_TRANSLATE = 1'b1;

endpackage

@@ src/pat_if.sv @@
// ----------------------------------------------------------------------------
// Paged address translation channels
// Request and response word channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pat_req_if;
	import pat_pkg::*;

	logic                valid;
	logic                ready;
	logic                mode;
	logic [ENTRY_W-1:0]  entry_index;
	logic [FRAME_W-1:0]  frame_number;
	logic [ADDR_W-1:0]   logical_address;

	modport source (output valid, mode, entry_index, frame_number, logical_address,
		input ready);
	modport sink (input valid, mode, entry_index, frame_number, logical_address,
		output ready);
endinterface

interface pat_rsp_if;
	import pat_pkg::*;

	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   physical_address;
	logic [STATUS_W-1:0] status;

	modport source (output valid, physical_address, status, input ready);
	modport sink (input valid, physical_address, status, output ready);
endinterface

@@ src/paged_address_translation_top.sv @@
// ----------------------------------------------------------------------------
// Paged address translation
// Translates logical addresses through a single-level frame table.
//
// channel  dir  word                                           handshake
// req      in   mode, entry_index, frame_number, logical_addr  valid/ready
// rsp      out  physical_address, status                       valid/ready
// cfg      in   cfg_index, cfg_data                            cfg_we
//
// A table write or a zero page size goes from acceptance straight to the
// output load. A translation takes 32 divider steps, a table read, a
// multiply and the output load; a page out of range skips the multiply.
// req.ready is high only while the sequencer is idle.
// A held result on rsp stalls only the final load; reset needs no sweep.
// ----------------------------------------------------------------------------
module paged_address_translation_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pat_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pat_pkg::CFG_W-1:0]     cfg_data,
	pat_req_if.sink                       req,
	pat_rsp_if.source                     rsp
);
	import pat_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]          state_q;
	logic [PSIZE_W-1:0]  page_size_q;
	logic [PAGES_W-1:0]  pages_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [ADDR_W-1:0]   prod_q;
	logic                rsp_valid_q;
	logic [ADDR_W-1:0]   rsp_addr_q;
	logic [STATUS_W-1:0] rsp_status_q;

	logic                accept;
	logic                div_start;
	logic                div_busy;
	logic                div_done;
	logic [ADDR_W-1:0]   div_quo;
	logic [PSIZE_W-1:0]  div_rem;
	logic                tbl_we;
	logic [FRAME_W-1:0]  tbl_rdata;
	logic [PAGES_W-1:0]  limit;
	logic                page_bad;
	logic [ADDR_W:0]     prod_full;
	logic                out_free;

	assign accept    = req.valid && req.ready;
	assign div_start = accept && (req.mode == MODE_TRANSLATE) && (page_size_q != '0);
	assign tbl_we    = accept && (req.mode == MODE_WRITE)
		&& (32'(req.entry_index) < TABLE_ENTRIES);
	assign limit     = (32'(pages_q) > TABLE_ENTRIES) ? PAGES_W'(TABLE_ENTRIES) : pages_q;
	assign page_bad  = div_quo >= ADDR_W'(limit);
	assign prod_full = (ADDR_W+1)'(tbl_rdata) * (ADDR_W+1)'(page_size_q);
	assign out_free  = !rsp_valid_q || rsp.ready;

	pat_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (req.logical_address),
		.divisor   (page_size_q),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	pat_table u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (IDX_W'(req.entry_index)),
		.wdata (req.frame_number),
		.re    (div_done),
		.raddr (IDX_W'(div_quo)),
		.rdata (tbl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q <= PAGE_SIZE_RST;
			pages_q     <= PAGES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAGE_SIZE:    page_size_q <= PSIZE_W'(cfg_data);
				REG_PAGES_IN_USE: pages_q     <= PAGES_W'(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			res_status_q <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.mode == MODE_WRITE) begin
							res_status_q <= ST_WRITTEN;
							state_q      <= S_DONE;
						end else if (page_size_q == '0) begin
							res_status_q <= ST_INVALID;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (page_bad) begin
							res_status_q <= ST_INVALID;
							state_q      <= S_DONE;
						end else begin
							res_status_q <= ST_OK;
							state_q      <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			prod_q <= prod_full[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			rsp_status_q <= res_status_q;
			rsp_addr_q   <= (res_status_q == ST_OK) ? prod_q + ADDR_W'(div_rem) : '0;
		end
	end

	assign req.ready            = (state_q == S_IDLE);
	assign rsp.valid            = rsp_valid_q;
	assign rsp.physical_address = rsp_addr_q;
	assign rsp.status           = rsp_status_q;

	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !div_busy)
		else $error("request taken while divider busy");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside divide state");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (state_q == S_DIV) && div_busy)
		else $error("divide not started");

	a_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != ST_OK)) |-> (rsp.physical_address == '0))
		else $error("non-zero address on failed or write word");

endmodule

@@ src/pat_div.sv @@
// ----------------------------------------------------------------------------
// Paged address translation divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pat_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pat_pkg::ADDR_W-1:0]   dividend,
	input  logic [pat_pkg::PSIZE_W-1:0]  divisor,
	output logic                         busy,
	output logic                         done,
	output logic [pat_pkg::ADDR_W-1:0]   quotient,
	output logic [pat_pkg::PSIZE_W-1:0]  remainder
);
	import pat_pkg::*;

	logic [ADDR_W-1:0]  quo_q;
	logic [PSIZE_W-1:0] rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [PSIZE_W:0]   trial;
	logic [PSIZE_W:0]   diff;
	logic               fits;

	assign trial = {rem_q, quo_q[ADDR_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DIV_STEPS);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[ADDR_W-2:0], fits};
			rem_q <= fits ? diff[PSIZE_W-1:0] : trial[PSIZE_W-1:0];
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

@@ src/pat_table.sv @@
// ----------------------------------------------------------------------------
// Paged address translation frame table
// Single-port-write, single-port-read frame store with registered read data.
// ----------------------------------------------------------------------------
module pat_table (
	input  logic                        clk,
	input  logic                        we,
	input  logic [pat_pkg::IDX_W-1:0]   waddr,
	input  logic [pat_pkg::FRAME_W-1:0] wdata,
	input  logic                        re,
	input  logic [pat_pkg::IDX_W-1:0]   raddr,
	output logic [pat_pkg::FRAME_W-1:0] rdata
);
	import pat_pkg::*;

	logic [FRAME_W-1:0] mem [TABLE_ENTRIES];
	logic [FRAME_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
